>>> hdl/twv_pkg.sv
// Shared types, constants and the cosine table builder for the Tukey window core.
// No dependencies; imported by twv_recip and tukey_window_value_core.
package twv_pkg;

   // configuration and field widths
   localparam int DATA_W          = 17;
   localparam int COS_TABLE_DEPTH = 1024;
   localparam logic [DATA_W-1:0] Q16_ONE     = DATA_W'(65536);
   localparam logic [DATA_W-1:0] ALPHA_RESET = DATA_W'(32768);

   // taper distance d is always below one half, so 15 bits
   localparam int DIST_W = 15;
   // numerator 4*D*d + alpha/2 stays below 2^15 * (4*D + 1)
   localparam int NUM_W   = $clog2(4 * COS_TABLE_DEPTH + 1) + DIST_W;
   // reciprocal floor(2^NUM_W / alpha), alpha down to one
   localparam int RECIP_W = NUM_W + 1;
   localparam int LO_W    = 16;
   localparam int HI_W    = RECIP_W - LO_W;
   // phase index 0 .. 2*D and table address 0 .. D
   localparam int IDX_W   = $clog2(2 * COS_TABLE_DEPTH + 1);
   localparam int ADDR_W  = $clog2(COS_TABLE_DEPTH + 1);
   localparam int CNT_W   = $clog2(NUM_W + 1);

   localparam longint unsigned RECIP_RESET_L = (64'd1 << NUM_W) / 64'd32768;
   localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(RECIP_RESET_L);

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   // table depth and its half as 64-bit constants for the table builder
   localparam longint unsigned DEPTH_L      = 64'(COS_TABLE_DEPTH);
   localparam longint unsigned HALF_DEPTH_L = 64'(COS_TABLE_DEPTH / 2);

   typedef logic [DATA_W-1:0] rom_type [0:COS_TABLE_DEPTH];

   // request into the reciprocal unit
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] divisor;
   } recip_req_type;

   // status out of the reciprocal unit
   typedef struct packed {
      logic               busy;
      logic [RECIP_W-1:0] value;
   } recip_rsp_type;

   // quarter-wave cosine table in Q16, Taylor series to t^12 in Q30
   function automatic rom_type build_cos_rom();
      rom_type         rom;
      longint unsigned theta;
      longint unsigned t2;
      longint unsigned r;
      longint unsigned p;
      longint unsigned q;
      for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
         theta = (PI_HALF_Q30 * longint'(k) + HALF_DEPTH_L) / DEPTH_L;
         t2    = (theta * theta) >> 30;
         r     = Q30_ONE;
         for (int i = 0; i < 6; i++) begin
            p = (t2 * r) >> 30;
            case (i)
               0:       q = p / 64'd132;
               1:       q = p / 64'd90;
               2:       q = p / 64'd56;
               3:       q = p / 64'd30;
               4:       q = p / 64'd12;
               default: q = p / 64'd2;
            endcase
            r = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
         end
         rom[k] = DATA_W'((r + 64'd8192) >> 14);
      end
      return rom;
   endfunction

endpackage

>>> hdl/twv_recip.sv
// Bit-serial restoring divider producing floor(2^NUM_W / alpha).
// Depends on twv_pkg for widths and the request and status structs.
module twv_recip (
   input  logic                   clock,
   input  logic                   reset,
   input  twv_pkg::recip_req_type req,
   output twv_pkg::recip_rsp_type rsp
);
   import twv_pkg::*;

   logic               busy_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DATA_W:0]    rem_ff;
   logic [RECIP_W-1:0] quo_ff;
   logic [DATA_W-1:0]  div_ff;

   logic [DATA_W:0]    rem_sh;
   logic               ge;
   logic [DATA_W:0]    rem_in;

   // one quotient bit per cycle, dividend is a single one at bit NUM_W
   always_comb begin
      rem_sh = {rem_ff[DATA_W-1:0], (cnt_ff == CNT_W'(NUM_W))};
      ge     = rem_sh >= {1'b0, div_ff};
      rem_in = ge ? rem_sh - {1'b0, div_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= RECIP_RESET;
         div_ff  <= ALPHA_RESET;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NUM_W);
         rem_ff  <= '0;
         quo_ff  <= '0;
         div_ff  <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[RECIP_W-2:0], ge};
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign rsp.busy  = busy_ff;
   assign rsp.value = quo_ff;

endmodule

>>> hdl/tukey_window_value_core.sv
// Tukey (tapered cosine) window gain: eight-stage pipeline with cosine ROM.
// Depends on twv_pkg and instantiates twv_recip for the 1/alpha reciprocal.
//
// Takes one position beat per clock while the output side keeps up and the
// reciprocal divider is idle, and returns its gain beat from the stage 8
// register; each stage holds under backpressure and bubbles are squeezed out.
// The phase index division by alpha is a multiply by a stored reciprocal plus
// one correction step, and the cosine comes from a registered read of a
// COS_TABLE_DEPTH+1 entry quarter-wave ROM. A write to the taper register
// starts the bit-serial reciprocal divider; req_ready is low during that write
// and while the divider runs. After reset the reciprocal for the reset taper
// is already in place.
module tukey_window_value_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [twv_pkg::DATA_W-1:0] req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [twv_pkg::DATA_W-1:0] rsp_gain,
   input  logic                       csr_we,
   input  logic [twv_pkg::DATA_W-1:0] csr_wdata
);
   import twv_pkg::*;

   localparam int STAGES = 8;
   localparam int QA_W   = IDX_W + DATA_W;
   localparam int REM_W  = (QA_W > NUM_W) ? QA_W : NUM_W;
   localparam int PROD_W = NUM_W + RECIP_W;
   localparam rom_type COS_ROM = build_cos_rom();

   // taper register, stored already clamped to 1 .. 1.0
   logic [DATA_W-1:0] alpha_ff;
   logic [DATA_W-1:0] alpha_in;
   recip_req_type     recip_req;
   recip_rsp_type     recip_rsp;

   always_comb begin
      if (csr_wdata == '0) begin
         alpha_in = DATA_W'(1);
      end else if (csr_wdata > Q16_ONE) begin
         alpha_in = Q16_ONE;
      end else begin
         alpha_in = csr_wdata;
      end
      recip_req.start   = csr_we;
      recip_req.divisor = alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_we) begin
         alpha_ff <= alpha_in;
      end
   end

   twv_recip u_recip (
      .clock (clock),
      .reset (reset),
      .req   (recip_req),
      .rsp   (recip_rsp)
   );

   // pipeline valid bits and per-stage load enables
   logic [STAGES:1] vld_ff;
   logic [STAGES:1] rdy;

   always_comb begin
      rdy[STAGES] = !vld_ff[STAGES] || rsp_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_ready = rdy[1] && !recip_rsp.busy && !csr_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[1]) begin
            vld_ff[1] <= req_valid && req_ready;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 1: clamp position, pick the taper side, build the numerator
   logic [DATA_W-1:0] x_sat;
   logic [DATA_W-1:0] x_comp;
   logic              attack;
   logic              release_side;
   logic [DIST_W-1:0] offset;
   logic [NUM_W-1:0]  num_in;
   logic [NUM_W-1:0]  num1_ff;
   logic              flat1_ff;

   always_comb begin
      x_sat        = (req_position > Q16_ONE) ? Q16_ONE : req_position;
      x_comp       = Q16_ONE - x_sat;
      attack       = {x_sat, 1'b0} < {1'b0, alpha_ff};
      release_side = {x_comp, 1'b0} < {1'b0, alpha_ff};
      offset       = attack ? x_sat[DIST_W-1:0] : x_comp[DIST_W-1:0];
      num_in       = NUM_W'(offset) * NUM_W'(4 * COS_TABLE_DEPTH)
                     + NUM_W'(alpha_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         num1_ff  <= num_in;
         flat1_ff <= !attack && !release_side;
      end
   end

   // stage 2: partial products of numerator and reciprocal
   logic [NUM_W+LO_W-1:0] pp_lo2_ff;
   logic [NUM_W+HI_W-1:0] pp_hi2_ff;
   logic [NUM_W-1:0]      num2_ff;
   logic                  flat2_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         pp_lo2_ff <= (NUM_W+LO_W)'(num1_ff) * (NUM_W+LO_W)'(recip_rsp.value[LO_W-1:0]);
         pp_hi2_ff <= (NUM_W+HI_W)'(num1_ff)
                      * (NUM_W+HI_W)'(recip_rsp.value[RECIP_W-1:LO_W]);
         num2_ff   <= num1_ff;
         flat2_ff  <= flat1_ff;
      end
   end

   // stage 3: sum partial products, quotient estimate is exact or one low
   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0]  q3_ff;
   logic [NUM_W-1:0]  num3_ff;
   logic              flat3_ff;

   always_comb begin
      prod = PROD_W'(pp_lo2_ff) + (PROD_W'(pp_hi2_ff) << LO_W);
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         q3_ff    <= prod[NUM_W +: IDX_W];
         num3_ff  <= num2_ff;
         flat3_ff <= flat2_ff;
      end
   end

   // stage 4: back-multiply the estimate by alpha
   logic [QA_W-1:0]  qa4_ff;
   logic [IDX_W-1:0] q4_ff;
   logic [NUM_W-1:0] num4_ff;
   logic             flat4_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         qa4_ff   <= QA_W'(q3_ff) * QA_W'(alpha_ff);
         q4_ff    <= q3_ff;
         num4_ff  <= num3_ff;
         flat4_ff <= flat3_ff;
      end
   end

   // stage 5: remainder check fixes the estimate, clamp to half wave
   logic [REM_W-1:0] rem;
   logic [IDX_W:0]   q_inc;
   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] idx5_ff;
   logic             flat5_ff;

   always_comb begin
      rem   = REM_W'(num4_ff) - REM_W'(qa4_ff);
      q_inc = {1'b0, q4_ff} + (IDX_W+1)'(rem >= REM_W'(alpha_ff));
      if (q_inc > (IDX_W+1)'(2 * COS_TABLE_DEPTH)) begin
         idx_in = IDX_W'(2 * COS_TABLE_DEPTH);
      end else begin
         idx_in = q_inc[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         idx5_ff  <= idx_in;
         flat5_ff <= flat4_ff;
      end
   end

   // stage 6: fold the second quarter onto the table
   logic              upper_in;
   logic [IDX_W-1:0]  fold;
   logic [ADDR_W-1:0] addr6_ff;
   logic              upper6_ff;
   logic              flat6_ff;

   always_comb begin
      upper_in = idx5_ff > IDX_W'(COS_TABLE_DEPTH);
      fold     = upper_in ? IDX_W'(2 * COS_TABLE_DEPTH) - idx5_ff : idx5_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         addr6_ff  <= fold[ADDR_W-1:0];
         upper6_ff <= upper_in;
         flat6_ff  <= flat5_ff;
      end
   end

   // stage 7: registered cosine rom read
   logic [DATA_W-1:0] cos7_ff;
   logic              upper7_ff;
   logic              flat7_ff;

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         cos7_ff   <= COS_ROM[addr6_ff];
         upper7_ff <= upper6_ff;
         flat7_ff  <= flat6_ff;
      end
   end

   // stage 8: raised cosine gain into the output register
   logic [DATA_W:0]   y_up;
   logic [DATA_W:0]   y_lo;
   logic [DATA_W-1:0] gain_in;
   logic [DATA_W-1:0] gain8_ff;

   always_comb begin
      y_up = ({1'b0, Q16_ONE} + {1'b0, cos7_ff} + (DATA_W+1)'(1)) >> 1;
      y_lo = ({1'b0, Q16_ONE} + (DATA_W+1)'(1) - {1'b0, cos7_ff}) >> 1;
      if (flat7_ff) begin
         gain_in = Q16_ONE;
      end else if (upper7_ff) begin
         gain_in = (y_up > {1'b0, Q16_ONE}) ? Q16_ONE : y_up[DATA_W-1:0];
      end else if (cos7_ff > Q16_ONE) begin
         gain_in = '0;
      end else begin
         gain_in = y_lo[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         gain8_ff <= gain_in;
      end
   end

   assign rsp_valid = vld_ff[STAGES];
   assign rsp_gain  = gain8_ff;

endmodule
